>>> hw/rtl/ocg_pkg.sv
`timescale 1ns / 1ps

package ocg_pkg;

  // Storage depth and derived widths
  localparam int MAX_PENDING = 16;
  localparam int TICKET_W    = 64;
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int IDX_W       = $clog2(MAX_PENDING);
  localparam int COUNT_OUT_W = 5;

  // Operation codes
  typedef enum logic [1:0] {
    FN_ISSUE  = 2'd0,
    FN_RETIRE = 2'd1,
    FN_CHECK  = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_ORDER       = 2'd1,
    STAT_FULL        = 2'd2,
    STAT_NOT_PENDING = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } state_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    logic load_en;
  } cell_ctl_t;

endpackage

>>> hw/rtl/ocg_cell.sv
`timescale 1ns / 1ps

module ocg_cell import ocg_pkg::*; (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic                in_use,
  input  logic                load_here,
  input  logic [TICKET_W-1:0] ticket_in,
  input  logic [TICKET_W-1:0] right_val,
  input  logic                hit_in,
  output logic [TICKET_W-1:0] value,
  output logic                hit_out,
  output logic                eq_now,
  output logic                lt
);

  logic eq;

  // Compare the held ticket against the transaction's ticket
  assign eq_now = (value == ticket_in);

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      eq <= eq_now & in_use;
      lt <= (value < ticket_in);
    end
  end

  // Match seen at this cell or any older one: this cell takes its neighbor's value
  assign hit_out = hit_in | eq;

  // Slot update: close the gap on retire, append on issue
  always_ff @(posedge clk) begin
    if (ctl.shift_en && hit_out) begin
      value <= right_val;
    end else if (ctl.load_en && load_here) begin
      value <= ticket_in;
    end
  end

endmodule

>>> hw/rtl/ordered_commit_gate_top.sv
`timescale 1ns / 1ps

// Ordered commit gate: holds up to MAX_PENDING ticket numbers oldest first in a
// chain of cells. Issue appends a ticket that must exceed the tail, retire removes
// a ticket anywhere and closes the gap, check changes nothing; each transaction
// returns one result with status, head ticket, whether the input ticket is at the
// head, and the pending count. After acceptance an item passes through the states
// S_CMP, where every cell compares its slot with the ticket, S_UPD, where the cells
// shift or load, and S_OUT, where the result is formed from the new head and loaded
// into the output register. The next item is accepted in S_OUT when the output
// register is free, so the block takes no new item until the last one reaches
// S_OUT; a held output register stalls the input until it is taken.

module ordered_commit_gate_top import ocg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             func,
  input  logic [TICKET_W-1:0]    ticket,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic                   ticket_at_head,
  output logic                   head_valid,
  output logic [TICKET_W-1:0]    head_ticket,
  output logic [COUNT_OUT_W-1:0] pending_count
);

  state_t              state, state_next;
  logic [1:0]          func_r;
  logic [TICKET_W-1:0] ticket_r;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [1:0]          status_r;
  logic [1:0]          status_next;

  cell_ctl_t           ctl;
  logic                in_acc;
  logic                out_load;
  logic                out_free;
  logic                full;
  logic                tail_lt;
  logic [CNT_W-1:0]    cnt_dec;

  logic [TICKET_W-1:0] vals   [MAX_PENDING];
  logic [MAX_PENDING:0] hit;
  logic [MAX_PENDING-1:0] eq_now;
  logic [MAX_PENDING-1:0] lt_vec;

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Chain of slot cells, oldest at cell 0
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < MAX_PENDING; i++) begin : g_cell
    logic [TICKET_W-1:0] right_val;
    if (i == MAX_PENDING - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = vals[i+1];
    end

    ocg_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_use    (CNT_W'(i) < count),
      .load_here (count == CNT_W'(i)),
      .ticket_in (ticket_r),
      .right_val (right_val),
      .hit_in    (hit[i]),
      .value     (vals[i]),
      .hit_out   (hit[i+1]),
      .eq_now    (eq_now[i]),
      .lt        (lt_vec[i])
    );
  end

  // Tail order test and fullness
  assign cnt_dec = count - CNT_W'(1);
  assign tail_lt = lt_vec[cnt_dec[IDX_W-1:0]];
  assign full    = (count == CNT_W'(MAX_PENDING));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = in_acc ? S_CMP : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs and update decision
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    ctl          = '0;
    status_next  = STAT_OK;
    count_next   = count;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_CMP:  ctl.cmp_en = 1'b1;
      S_UPD: begin
        case (func_r)
          FN_ISSUE: begin
            if (full) begin
              status_next = STAT_FULL;
            end else if (count != '0 && !tail_lt) begin
              status_next = STAT_ORDER;
            end else begin
              ctl.load_en = 1'b1;
              count_next  = count + CNT_W'(1);
            end
          end
          FN_RETIRE: begin
            if (!hit[MAX_PENDING]) begin
              status_next = STAT_NOT_PENDING;
            end else begin
              ctl.shift_en = 1'b1;
              count_next   = cnt_dec;
            end
          end
          default: status_next = STAT_OK;
        endcase
      end
      S_OUT: begin
        out_load = out_free;
        in_ready = out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD) begin
        count <= count_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction and result payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= func;
      ticket_r <= ticket;
    end
    if (state == S_UPD) begin
      status_r <= status_next;
    end
    if (out_load) begin
      status         <= status_r;
      ticket_at_head <= (count != '0) & eq_now[0];
      head_valid     <= (count != '0);
      head_ticket    <= (count != '0) ? vals[0] : '0;
      pending_count  <= COUNT_OUT_W'(count);
    end
  end

endmodule

>>> hw/rtl/ocg_checker.sv
`timescale 1ns / 1ps

module ocg_checker import ocg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             status,
  input logic                   ticket_at_head,
  input logic                   head_valid,
  input logic [TICKET_W-1:0]    head_ticket,
  input logic [COUNT_OUT_W-1:0] pending_count
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Head valid tracks a nonzero count
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_valid == (pending_count != '0)))
    else $error("head_valid disagrees with pending_count");

  // Entry condition only with a pending head
  a_at_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && ticket_at_head |-> head_valid)
    else $error("ticket_at_head with empty list");

  // Empty list reports a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> head_ticket == '0)
    else $error("nonzero head ticket on empty list");

  // Full report only at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> pending_count == COUNT_OUT_W'(MAX_PENDING))
    else $error("full status below capacity");

  // Result status and pending count hold while the result waits
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pending_count))
    else $error("result changed while waiting");

endmodule

bind ordered_commit_gate_top ocg_checker u_ocg_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .ticket_at_head (ticket_at_head),
  .head_valid     (head_valid),
  .head_ticket    (head_ticket),
  .pending_count  (pending_count)
);
